/* design/tplc_pkg.sv */
package tplc_pkg;

    localparam int LEVEL_W = 10;
    localparam int TICK_W  = 8;
    localparam int ROUND_W = 4;
    localparam int PHASE_W = 4;
    localparam int COLOR_W = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CUTOFF_LEVEL    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WARN_LEVEL      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_OFF_TICKS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_ON_TICKS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_ROUNDS    = 3'd5;

    localparam logic [LEVEL_W-1:0] CUTOFF_LEVEL_RST    = 10'd100;
    localparam logic [LEVEL_W-1:0] WARN_LEVEL_RST      = 10'd250;
    localparam logic [LEVEL_W-1:0] HYSTERESIS_RST      = 10'd50;
    localparam logic [TICK_W-1:0]  BLINK_OFF_TICKS_RST = 8'd4;
    localparam logic [TICK_W-1:0]  BLINK_ON_TICKS_RST  = 8'd10;
    localparam logic [ROUND_W-1:0] BLINK_ROUNDS_RST    = 4'd4;

    localparam logic [PHASE_W-1:0] PH_START         = 4'd0;
    localparam logic [PHASE_W-1:0] PH_SWITCH_ON     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_NORMAL        = 4'd2;
    localparam logic [PHASE_W-1:0] PH_WARN_BLINK    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_WARN_WAIT     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_EMPTY_CUTOFF  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_EMPTY_WAIT    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_MANUAL_TOGGLE = 4'd7;
    localparam logic [PHASE_W-1:0] PH_MANUAL_WAIT   = 4'd8;

    localparam logic [COLOR_W-1:0] COLOR_NORMAL = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd2;

    localparam logic LED_LEVEL   = 1'b0;
    localparam logic LED_WARNING = 1'b1;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_permille;
        logic               flow_outward;
        logic               manual_press;
    } in_item_t;

    typedef struct packed {
        logic               pump_on;
        logic               led_warning;
        logic [COLOR_W-1:0] led_color;
        logic [PHASE_W-1:0] phase;
    } out_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] cutoff_level;
        logic [LEVEL_W-1:0] warn_level;
        logic [LEVEL_W-1:0] hysteresis;
        logic [TICK_W-1:0]  blink_off_ticks;
        logic [TICK_W-1:0]  blink_on_ticks;
        logic [ROUND_W-1:0] blink_rounds;
    } cfg_t;

endpackage

/* design/tplc_cfg_regs.sv */
module tplc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [tplc_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [tplc_pkg::CFG_DATA_W-1:0]     wr_data,
    output tplc_pkg::cfg_t                      cfg
);
    import tplc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_CUTOFF_LEVEL:    cfg_next.cutoff_level    = wr_data[LEVEL_W-1:0];
                REG_WARN_LEVEL:      cfg_next.warn_level      = wr_data[LEVEL_W-1:0];
                REG_HYSTERESIS:      cfg_next.hysteresis      = wr_data[LEVEL_W-1:0];
                REG_BLINK_OFF_TICKS: cfg_next.blink_off_ticks = wr_data[TICK_W-1:0];
                REG_BLINK_ON_TICKS:  cfg_next.blink_on_ticks  = wr_data[TICK_W-1:0];
                REG_BLINK_ROUNDS:    cfg_next.blink_rounds    = wr_data[ROUND_W-1:0];
                default:             cfg_next = cfg_reg;  // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cutoff_level    <= CUTOFF_LEVEL_RST;
            cfg_reg.warn_level      <= WARN_LEVEL_RST;
            cfg_reg.hysteresis      <= HYSTERESIS_RST;
            cfg_reg.blink_off_ticks <= BLINK_OFF_TICKS_RST;
            cfg_reg.blink_on_ticks  <= BLINK_ON_TICKS_RST;
            cfg_reg.blink_rounds    <= BLINK_ROUNDS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/tplc_ctrl.sv */
module tplc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  tplc_pkg::in_item_t   item,
    input  tplc_pkg::cfg_t       cfg,
    output tplc_pkg::out_item_t  result
);
    import tplc_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               pump_reg, pump_next;
    logic               latch_reg, latch_next;
    logic [TICK_W-1:0]  tick_cnt_reg, tick_cnt_next;
    logic [ROUND_W-1:0] round_cnt_reg, round_cnt_next;
    logic               led_mode_reg, led_mode_next;
    logic [COLOR_W-1:0] led_color_reg, led_color_next;

    logic                latch_eff;
    logic [TICK_W-1:0]   tick_inc;
    logic [ROUND_W-1:0]  round_inc;
    logic [LEVEL_W:0]    level_x;
    logic [LEVEL_W:0]    cutoff_x;
    logic [LEVEL_W:0]    warn_x;
    logic [LEVEL_W:0]    warn_recover;
    logic [LEVEL_W:0]    empty_recover;

    always_comb
    begin
        latch_eff     = latch_reg | item.manual_press;
        tick_inc      = tick_cnt_reg + 1'b1;
        round_inc     = round_cnt_reg + 1'b1;
        level_x       = {1'b0, item.level_permille};
        cutoff_x      = {1'b0, cfg.cutoff_level};
        warn_x        = {1'b0, cfg.warn_level};
        warn_recover  = warn_x + {1'b0, cfg.hysteresis};
        empty_recover = cutoff_x + {1'b0, cfg.hysteresis};

        phase_next     = phase_reg;
        pump_next      = pump_reg;
        latch_next     = latch_eff;
        tick_cnt_next  = tick_cnt_reg;
        round_cnt_next = round_cnt_reg;
        led_mode_next  = led_mode_reg;
        led_color_next = led_color_reg;

        unique case (phase_reg)
            PH_START:
            begin
                pump_next  = 1'b0;
                phase_next = PH_SWITCH_ON;
            end
            PH_SWITCH_ON:
            begin
                if (level_x > cutoff_x)
                begin
                    pump_next = 1'b1;
                end
                led_mode_next  = LED_LEVEL;
                led_color_next = COLOR_NORMAL;
                phase_next     = PH_NORMAL;
            end
            PH_NORMAL:
            begin
                priority if (latch_eff)
                begin
                    phase_next = PH_MANUAL_TOGGLE;
                end
                else if (level_x < warn_x && item.flow_outward)
                begin
                    led_mode_next  = LED_WARNING;
                    led_color_next = COLOR_YELLOW;
                    pump_next      = 1'b0;
                    tick_cnt_next  = '0;
                    round_cnt_next = '0;
                    phase_next     = PH_WARN_BLINK;
                end
            end
            PH_WARN_BLINK:
            begin
                tick_cnt_next = tick_inc;
                if (!pump_reg)
                begin
                    if (tick_inc >= cfg.blink_off_ticks)
                    begin
                        pump_next     = 1'b1;
                        tick_cnt_next = '0;
                    end
                end
                else if (tick_inc >= cfg.blink_on_ticks)
                begin
                    tick_cnt_next  = '0;
                    round_cnt_next = round_inc;
                    if (round_inc >= cfg.blink_rounds)
                    begin
                        // last round done: pump stays on
                        round_cnt_next = '0;
                        led_mode_next  = LED_LEVEL;
                        led_color_next = COLOR_NORMAL;
                        phase_next     = PH_WARN_WAIT;
                    end
                    else
                    begin
                        pump_next = 1'b0;
                    end
                end
            end
            PH_WARN_WAIT:
            begin
                priority if (level_x > warn_recover)
                begin
                    phase_next = PH_SWITCH_ON;
                end
                else if (level_x < cutoff_x)
                begin
                    phase_next = PH_EMPTY_CUTOFF;
                end
            end
            PH_EMPTY_CUTOFF:
            begin
                led_mode_next  = LED_WARNING;
                led_color_next = COLOR_RED;
                pump_next      = 1'b0;
                phase_next     = PH_EMPTY_WAIT;
            end
            PH_EMPTY_WAIT:
            begin
                priority if (latch_eff)
                begin
                    phase_next = PH_MANUAL_TOGGLE;
                end
                else if (level_x > empty_recover && !(level_x < cutoff_x))
                begin
                    phase_next = PH_SWITCH_ON;
                end
            end
            PH_MANUAL_TOGGLE:
            begin
                led_mode_next  = LED_WARNING;
                led_color_next = COLOR_NORMAL;
                pump_next      = ~pump_reg;
                latch_next     = 1'b0;
                phase_next     = PH_MANUAL_WAIT;
            end
            PH_MANUAL_WAIT:
            begin
                if (latch_eff)
                begin
                    latch_next = 1'b0;
                    phase_next = PH_SWITCH_ON;
                end
            end
            default:
            begin
                // unused phase code: everything holds but the manual latch, which still takes a press
                latch_next = latch_eff;
            end
        endcase

        result.pump_on     = pump_next;
        result.led_warning = led_mode_next;
        result.led_color   = led_color_next;
        result.phase       = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            pump_reg      <= 1'b0;
            latch_reg     <= 1'b0;
            tick_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            led_mode_reg  <= LED_LEVEL;
            led_color_reg <= COLOR_NORMAL;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            pump_reg      <= pump_next;
            latch_reg     <= latch_next;
            tick_cnt_reg  <= tick_cnt_next;
            round_cnt_reg <= round_cnt_next;
            led_mode_reg  <= led_mode_next;
            led_color_reg <= led_color_next;
        end
    end

    a_blink_led: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_WARN_BLINK |-> led_mode_reg == LED_WARNING
                                       && led_color_reg == COLOR_YELLOW)
        else $error("warn blink without yellow warning LED");

    a_empty_led: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_EMPTY_WAIT |-> led_mode_reg == LED_WARNING
                                       && led_color_reg == COLOR_RED && !pump_reg)
        else $error("empty wait with pump on or LED not red");

    a_manual_led: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_MANUAL_WAIT |-> led_mode_reg == LED_WARNING
                                        && led_color_reg == COLOR_NORMAL)
        else $error("manual wait with wrong LED state");

    a_start_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_START |=> phase_reg == PH_SWITCH_ON && !pump_reg)
        else $error("start phase did not move to switch on");

endmodule

/* design/tank_pump_level_controller.sv */
// An accepted item is held in the input register and stepped once the result register is free or
//   draining; its result then sits at out_item until taken (input register, then result register).
// Throughput: one item per cycle while out_ready is high; the input register refills in the cycle
//   the result register is loaded, so a stalled output only holds one item in each.
// Reset (rst_n low, asynchronous): start phase, pump off, LED level display normal,
//   counters and manual latch cleared, settings back to their defaults.
module tank_pump_level_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  tplc_pkg::in_item_t                 in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output tplc_pkg::out_item_t                out_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tplc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tplc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import tplc_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      step;
    cfg_t      cfg;
    out_item_t result;

    // step when a held item exists and the result slot is free or draining
    assign step      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    tplc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tplc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_item;
        end
        if (step)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("stepped item did not reach the result register");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_item_reg))
        else $error("held item lost before its step");

endmodule

/* tb/sv/tb_tank_pump_level_controller.sv */
`timescale 1ns / 1ps

module tb_tank_pump_level_controller;

    import tplc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int OUT_HOLD_CYCLES = 64;
    localparam int SWEEP_PHASES    = 12;
    localparam int ITEMS_PER_PHASE = 135;

    // indexes beyond the register map, the block must ignore them
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_item_t               in_item = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // controller state mirrored by the checker
    cfg_t settings = '{CUTOFF_LEVEL_RST, WARN_LEVEL_RST, HYSTERESIS_RST,
                       BLINK_OFF_TICKS_RST, BLINK_ON_TICKS_RST, BLINK_ROUNDS_RST};
    logic [PHASE_W-1:0] ctl_phase = PH_START;
    logic               pump = 1'b0;
    logic               man_latch = 1'b0;
    logic [TICK_W-1:0]  blink_ticks = '0;
    logic [ROUND_W-1:0] blink_rounds_done = '0;
    logic               led_mode = LED_LEVEL;
    logic [COLOR_W-1:0] led_colour = COLOR_NORMAL;

    out_item_t controller_outputs_due[$];
    out_item_t due;
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    bit        stall_request = 1'b0;
    int        walk_level = 600;
    bit        walk_draining = 1'b0;

    tank_pump_level_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic out_item_t step_controller(input in_item_t t);
        out_item_t          r;
        int unsigned        lvl;
        int unsigned        cut;
        int unsigned        warn;
        int unsigned        hyst;
        logic [PHASE_W-1:0] nxt;
        lvl  = t.level_permille;
        cut  = settings.cutoff_level;
        warn = settings.warn_level;
        hyst = settings.hysteresis;
        // press is latched ahead of the phase action
        if (t.manual_press)
            man_latch = 1'b1;
        case (ctl_phase)
            PH_START:
            begin
                pump = 1'b0;
                ctl_phase = PH_SWITCH_ON;
            end
            PH_SWITCH_ON:
            begin
                if (lvl > cut)
                    pump = 1'b1;
                led_mode = LED_LEVEL;
                led_colour = COLOR_NORMAL;
                ctl_phase = PH_NORMAL;
            end
            PH_NORMAL:
            begin
                if (man_latch)
                    ctl_phase = PH_MANUAL_TOGGLE;
                else if (lvl < warn && t.flow_outward)
                begin
                    led_mode = LED_WARNING;
                    led_colour = COLOR_YELLOW;
                    pump = 1'b0;
                    blink_ticks = '0;
                    blink_rounds_done = '0;
                    ctl_phase = PH_WARN_BLINK;
                end
            end
            PH_WARN_BLINK:
            begin
                blink_ticks = blink_ticks + 1'b1;
                if (!pump)
                begin
                    if (blink_ticks >= settings.blink_off_ticks)
                    begin
                        pump = 1'b1;
                        blink_ticks = '0;
                    end
                end
                else if (blink_ticks >= settings.blink_on_ticks)
                begin
                    blink_ticks = '0;
                    blink_rounds_done = blink_rounds_done + 1'b1;
                    if (blink_rounds_done >= settings.blink_rounds)
                    begin
                        blink_rounds_done = '0;
                        led_mode = LED_LEVEL;
                        led_colour = COLOR_NORMAL;
                        ctl_phase = PH_WARN_WAIT;
                    end
                    else
                        pump = 1'b0;
                end
            end
            PH_WARN_WAIT:
            begin
                nxt = PH_WARN_WAIT;
                if (lvl < cut)
                    nxt = PH_EMPTY_CUTOFF;
                if (lvl > warn + hyst)
                    nxt = PH_SWITCH_ON;
                ctl_phase = nxt;
            end
            PH_EMPTY_CUTOFF:
            begin
                led_mode = LED_WARNING;
                led_colour = COLOR_RED;
                pump = 1'b0;
                ctl_phase = PH_EMPTY_WAIT;
            end
            PH_EMPTY_WAIT:
            begin
                nxt = PH_EMPTY_WAIT;
                if (lvl > cut + hyst)
                    nxt = PH_SWITCH_ON;
                if (lvl < cut)
                    nxt = PH_EMPTY_WAIT;
                if (man_latch)
                    nxt = PH_MANUAL_TOGGLE;
                ctl_phase = nxt;
            end
            PH_MANUAL_TOGGLE:
            begin
                led_mode = LED_WARNING;
                led_colour = COLOR_NORMAL;
                pump = ~pump;
                man_latch = 1'b0;
                ctl_phase = PH_MANUAL_WAIT;
            end
            PH_MANUAL_WAIT:
            begin
                if (man_latch)
                begin
                    man_latch = 1'b0;
                    ctl_phase = PH_SWITCH_ON;
                end
            end
            default: ;
        endcase
        r.pump_on     = pump;
        r.led_warning = led_mode;
        r.led_color   = led_colour;
        r.phase       = ctl_phase;
        return r;
    endfunction

    // all handshakes seen from the pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (controller_outputs_due.size() == 0)
                begin
                    $error("result item with no tick outstanding");
                    mismatch_count++;
                end
                else
                begin
                    due = controller_outputs_due.pop_front();
                    if (out_item.pump_on !== due.pump_on)
                    begin
                        $error("pump_on: expected %0d, got %0d", due.pump_on, out_item.pump_on);
                        mismatch_count++;
                    end
                    if (out_item.led_warning !== due.led_warning)
                    begin
                        $error("led_warning: expected %0d, got %0d",
                               due.led_warning, out_item.led_warning);
                        mismatch_count++;
                    end
                    if (out_item.led_color !== due.led_color)
                    begin
                        $error("led_color: expected %0d, got %0d",
                               due.led_color, out_item.led_color);
                        mismatch_count++;
                    end
                    if (out_item.phase !== due.phase)
                    begin
                        $error("phase: expected %0d, got %0d", due.phase, out_item.phase);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CUTOFF_LEVEL:    settings.cutoff_level = cfg_data;
                    REG_WARN_LEVEL:      settings.warn_level = cfg_data;
                    REG_HYSTERESIS:      settings.hysteresis = cfg_data;
                    REG_BLINK_OFF_TICKS: settings.blink_off_ticks = cfg_data[TICK_W-1:0];
                    REG_BLINK_ON_TICKS:  settings.blink_on_ticks = cfg_data[TICK_W-1:0];
                    REG_BLINK_ROUNDS:    settings.blink_rounds = cfg_data[ROUND_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                controller_outputs_due.push_back(step_controller(in_item));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side; a stall request holds ready low for a long stretch
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (OUT_HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_tick(input int unsigned lvl, input bit outward, input bit press);
        in_item_t it;
        it.level_permille = lvl[LEVEL_W-1:0];
        it.flow_outward   = outward;
        it.manual_press   = press;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // mostly a slow level walk that crosses the thresholds, some pure noise
    task automatic send_random_tick();
        if ($urandom_range(99) < 10)
            send_tick($urandom_range(1023), 1'($urandom_range(1)), 1'($urandom_range(1)));
        else
        begin
            if ($urandom_range(99) < 3)
                walk_draining = !walk_draining;
            if (walk_draining)
                walk_level = walk_level - int'($urandom_range(15));
            else
                walk_level = walk_level + int'($urandom_range(15));
            if (walk_level < 0)
                walk_level = 0;
            if (walk_level > 1000)
                walk_level = 1000;
            send_tick(walk_level, walk_draining ^ ($urandom_range(99) < 5),
                      $urandom_range(99) < 3);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (controller_outputs_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] cut, warn, hyst,
                                 input logic [CFG_DATA_W-1:0] off_t, on_t, rounds,
                                 input bit poke_unused);
        wait_idle();
        write_register(REG_CUTOFF_LEVEL, cut);
        write_register(REG_WARN_LEVEL, warn);
        write_register(REG_HYSTERESIS, hyst);
        write_register(REG_BLINK_OFF_TICKS, off_t);
        write_register(REG_BLINK_ON_TICKS, on_t);
        write_register(REG_BLINK_ROUNDS, rounds);
        if (poke_unused)
            write_register(CFG_INDEX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
                           CFG_DATA_W'($urandom_range(1023)));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                tx_idle_pct = 36;
                rx_idle_pct = 78;
            end
            1:
            begin
                tx_idle_pct = 78;
                rx_idle_pct = 36;
            end
            default:
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    // walks every phase with zero blink settings so the blink is two ticks long
    task automatic test_directed_sequence();
        load_settings(CUTOFF_LEVEL_RST, WARN_LEVEL_RST, HYSTERESIS_RST, 0, 0, 0, 1'b0);
        send_tick(500, 0, 0);
        send_tick(100, 0, 0);   // level at cutoff: pump left off
        send_tick(1000, 0, 0);
        send_tick(0, 1, 1);     // latch wins over the drain
        send_tick(500, 0, 1);   // press in the toggle tick is consumed there
        send_tick(500, 0, 0);
        send_tick(500, 0, 1);
        send_tick(0, 0, 0);     // pump stays on at level 0
        send_tick(250, 1, 0);   // level at warn: no blink
        send_tick(249, 1, 0);
        send_tick(1023, 0, 0);
        send_tick(1023, 0, 0);
        send_tick(300, 0, 0);   // at warn plus hysteresis: hold
        send_tick(99, 1, 0);
        send_tick(1023, 0, 0);
        send_tick(150, 0, 0);   // at cutoff plus hysteresis: hold
        send_tick(50, 0, 1);
        send_tick(50, 0, 0);
        send_tick(50, 0, 1);
        send_tick(1000, 0, 0);
        send_tick(0, 1, 0);
        send_tick(0, 0, 0);
        send_tick(0, 0, 0);
        send_tick(301, 0, 0);
    endtask

    // settings left over from the last phase may land mid blink, which is intended
    task automatic test_settings_sweep();
        for (int ph = 0; ph < SWEEP_PHASES; ph++)
        begin
            set_idling(ph / 4);
            case (ph)
                0: load_settings(CUTOFF_LEVEL_RST, WARN_LEVEL_RST, HYSTERESIS_RST,
                                 BLINK_OFF_TICKS_RST, BLINK_ON_TICKS_RST, BLINK_ROUNDS_RST,
                                 1'b1);
                1: load_settings(0, 0, 0, 0, 0, 0, 1'b0);
                2: load_settings(1000, 1000, 1000, 10'h3FF, 1, 1, 1'b1);
                3: load_settings(0, 500, 0, 1, 255, 1, 1'b0);
                4: load_settings(200, 500, 0, 1, 2, 15, 1'b1);
                5: load_settings(600, 300, 100, 2, 3, 2, 1'b0);
                default: load_settings(CFG_DATA_W'($urandom_range(400)),
                                       CFG_DATA_W'($urandom_range(800)),
                                       CFG_DATA_W'($urandom_range(150)),
                                       CFG_DATA_W'(($urandom_range(3) << 8)
                                                   | $urandom_range(15)),
                                       CFG_DATA_W'(($urandom_range(3) << 8)
                                                   | $urandom_range(25)),
                                       CFG_DATA_W'(($urandom_range(63) << 4)
                                                   | $urandom_range(6)),
                                       1'($urandom_range(1)));
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_tick();
        end
    endtask

    task automatic test_output_backpressure();
        set_idling(2);
        stall_request = 1'b1;
        for (int n = 0; n < 20; n++)
            send_random_tick();
    endtask

    initial
    begin
        set_idling(0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_sequence();
        test_settings_sweep();
        test_output_backpressure();
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
